// ===== sv/lav_pkg.sv =====
package lav_pkg;

  localparam int FW        = 32;          // Q16.16 word
  localparam int QBITS     = 16;          // fraction bits
  localparam int UW        = QBITS + 2;   // normalized component, |v| <= 1.0
  localparam int WW        = 64;          // wide accumulator
  localparam int REM_W     = FW + QBITS;  // divider remainder
  localparam int SQ_STEPS  = FW;          // root bits of a 64-bit radicand
  localparam int DIV_STEPS = QBITS + 1;   // quotient never exceeds 1.0
  localparam int QDEPTH    = 2;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic [2:0][FW-1:0]   vec_t;
  typedef logic [2:0][UW-1:0]   uvec_t;
  typedef logic [1:0]           col_t;

  localparam col_t        LAST_COL = 2'd3;
  localparam logic [FW-1:0] Q_ONE  = 32'd65536;
  localparam wide_t QSCALE  = 64'sd65536;
  localparam wide_t FIX_MAX = 64'sd2147483647;
  localparam wide_t FIX_MIN = -64'sd2147483648;

  typedef struct packed {
    vec_t eye;
    vec_t up;
    vec_t f;
    logic fzero;
  } item_t;

  typedef struct packed {
    vec_t  eye;
    vec_t  up;
    uvec_t fn;
    logic  degen;
  } side_t;

  typedef struct packed {
    uvec_t s;
    vec_t  u;
    uvec_t f;
    vec_t  c3;
    logic  degen;
  } rec_t;

  function automatic logic [FW-1:0] sat32(input wide_t x);
    logic [FW-1:0] r;
    if (x > FIX_MAX) r = FIX_MAX[FW-1:0];
    else if (x < FIX_MIN) r = FIX_MIN[FW-1:0];
    else r = x[FW-1:0];
    return r;
  endfunction

  // truncates toward zero
  function automatic wide_t rescale(input wide_t x);
    return x / QSCALE;
  endfunction

endpackage

// ===== sv/lav_front.sv =====
module lav_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lav_pkg::vec_t  eye,
  input  lav_pkg::vec_t  center,
  input  lav_pkg::vec_t  up,
  output logic           push_valid,
  input  logic           push_ready,
  output lav_pkg::item_t push_item
);
  import lav_pkg::*;

  logic  fv;
  item_t fi;
  item_t item_next;

  assign req_ready  = !fv || push_ready;
  assign push_valid = fv;
  assign push_item  = fi;

  always_comb begin
    wide_t d;
    d = '0;
    item_next.eye = eye;
    item_next.up  = up;
    for (int i = 0; i < 3; i++) begin
      d = wide_t'($signed(center[i])) - wide_t'($signed(eye[i]));
      item_next.f[i] = sat32(d);
    end
    item_next.fzero = (item_next.f == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (req_ready) fv <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) fi <= item_next;
  end

endmodule

// ===== sv/lav_queue.sv =====
module lav_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  lav_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lav_pkg::item_t pop_item
);
  import lav_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         slots [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign push_ready = (cnt != CW'(QDEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_item   = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop) rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/lav_norm.sv =====
module lav_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           v_valid,
  input  lav_pkg::vec_t  v,
  input  lav_pkg::side_t side_in,
  output logic           n_valid,
  output lav_pkg::uvec_t n,
  output logic           zero,
  output lav_pkg::side_t side_out
);
  import lav_pkg::*;

  localparam int DL = DIV_STEPS - 1;

  function automatic logic [FW-1:0] mag32(input logic [FW-1:0] x);
    return x[FW-1] ? FW'(-$signed(x)) : x;
  endfunction

  // squares
  logic              a_valid;
  logic [2:0][WW-1:0] a_sq;
  vec_t              a_v;
  side_t             a_side;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= v_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a_sq[i] <= WW'(mag32(v[i])) * WW'(mag32(v[i]));
      a_v    <= v;
      a_side <= side_in;
    end
  end

  // integer square root, one result bit per stage
  logic          sq_valid [SQ_STEPS+1];
  logic [WW-1:0] sq_rem   [SQ_STEPS+1];
  logic [WW-1:0] sq_root  [SQ_STEPS+1];
  vec_t          sq_v     [SQ_STEPS+1];
  side_t         sq_side  [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_valid[0] <= 1'b0;
    else if (en) sq_valid[0] <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= a_sq[0] + a_sq[1] + a_sq[2];
      sq_root[0] <= '0;
      sq_v[0]    <= a_v;
      sq_side[0] <= a_side;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [WW-1:0] SQ_BIT = WW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [WW-1:0] trial;
    assign trial = sq_root[k] + SQ_BIT;

    always_ff @(posedge clk) begin
      if (rst) sq_valid[k+1] <= 1'b0;
      else if (en) sq_valid[k+1] <= sq_valid[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - trial;
          sq_root[k+1] <= (sq_root[k] >> 1) + SQ_BIT;
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k] >> 1;
        end
        sq_v[k+1]    <= sq_v[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // restoring divide of |v| * 1.0 by the length, one quotient bit per stage
  logic                  dv_valid [DIV_STEPS];
  logic [2:0][REM_W-1:0] dv_rem   [DIV_STEPS];
  logic [2:0][DL:0]      dv_q     [DIV_STEPS];
  logic [FW-1:0]         dv_len   [DIV_STEPS];
  logic [2:0]            dv_neg   [DIV_STEPS];
  side_t                 dv_side  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DL - j;
    logic                  src_valid;
    logic [2:0][REM_W-1:0] src_rem;
    logic [2:0][DL:0]      src_q;
    logic [FW-1:0]         src_len;
    logic [2:0]            src_neg;
    side_t                 src_side;
    logic [REM_W:0]        trial;

    if (j == 0) begin : g_src_first
      always_comb begin
        src_valid = sq_valid[SQ_STEPS];
        src_len   = sq_root[SQ_STEPS][FW-1:0];
        src_side  = sq_side[SQ_STEPS];
        src_q     = '0;
        for (int i = 0; i < 3; i++) begin
          src_neg[i] = sq_v[SQ_STEPS][i][FW-1];
          src_rem[i] = {mag32(sq_v[SQ_STEPS][i]), QBITS'(0)};
        end
      end
    end else begin : g_src_next
      always_comb begin
        src_valid = dv_valid[j-1];
        src_len   = dv_len[j-1];
        src_side  = dv_side[j-1];
        src_q     = dv_q[j-1];
        src_neg   = dv_neg[j-1];
        src_rem   = dv_rem[j-1];
      end
    end

    assign trial = (REM_W + 1)'(src_len) << SH;

    always_ff @(posedge clk) begin
      if (rst) dv_valid[j] <= 1'b0;
      else if (en) dv_valid[j] <= src_valid;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, src_rem[i]} >= trial) begin
            dv_rem[j][i] <= src_rem[i] - trial[REM_W-1:0];
            dv_q[j][i]   <= src_q[i] | (DIV_STEPS'(1) << SH);
          end else begin
            dv_rem[j][i] <= src_rem[i];
            dv_q[j][i]   <= src_q[i];
          end
        end
        dv_len[j]  <= src_len;
        dv_neg[j]  <= src_neg;
        dv_side[j] <= src_side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else if (en) n_valid <= dv_valid[DL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n[i] <= dv_neg[DL][i] ? -{1'b0, dv_q[DL][i]} : {1'b0, dv_q[DL][i]};
      end
      zero     <= (dv_len[DL] == '0);
      side_out <= dv_side[DL];
    end
  end

endmodule

// ===== sv/lav_back.sv =====
module lav_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lav_pkg::item_t     in_item,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] elem_row0,
  output logic signed [31:0] elem_row1,
  output logic signed [31:0] elem_row2,
  output logic signed [31:0] elem_row3,
  output lav_pkg::col_t      column,
  output logic               last,
  output logic               degenerate
);
  import lav_pkg::*;

  localparam int PW1 = UW + FW;
  localparam int PW2 = 2 * UW;

  logic en;
  logic fin_valid;
  rec_t fin;

  // forward normalize
  side_t side0;
  logic  v1;
  uvec_t n1;
  logic  z1;
  side_t side1;

  always_comb begin
    side0.eye   = in_item.eye;
    side0.up    = in_item.up;
    side0.fn    = '0;
    side0.degen = in_item.fzero;
  end

  lav_norm u_norm_f (
    .clk(clk), .rst(rst), .en(en),
    .v_valid(in_valid), .v(in_item.f), .side_in(side0),
    .n_valid(v1), .n(n1), .zero(z1), .side_out(side1)
  );

  // side = forward x up
  logic                  c1_valid;
  logic signed [PW1-1:0] c1_p [6];
  side_t                 c1_side;

  always_ff @(posedge clk) begin
    if (rst) c1_valid <= 1'b0;
    else if (en) c1_valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p[0] <= $signed(n1[1]) * $signed(side1.up[2]);
      c1_p[1] <= $signed(n1[2]) * $signed(side1.up[1]);
      c1_p[2] <= $signed(n1[2]) * $signed(side1.up[0]);
      c1_p[3] <= $signed(n1[0]) * $signed(side1.up[2]);
      c1_p[4] <= $signed(n1[0]) * $signed(side1.up[1]);
      c1_p[5] <= $signed(n1[1]) * $signed(side1.up[0]);
      c1_side.eye   <= side1.eye;
      c1_side.up    <= side1.up;
      c1_side.fn    <= n1;
      c1_side.degen <= side1.degen | z1;
    end
  end

  logic  c2_valid;
  vec_t  c2_s;
  side_t c2_side;

  always_ff @(posedge clk) begin
    if (rst) c2_valid <= 1'b0;
    else if (en) c2_valid <= c1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_s[0] <= sat32(rescale(wide_t'(c1_p[0]) - wide_t'(c1_p[1])));
      c2_s[1] <= sat32(rescale(wide_t'(c1_p[2]) - wide_t'(c1_p[3])));
      c2_s[2] <= sat32(rescale(wide_t'(c1_p[4]) - wide_t'(c1_p[5])));
      c2_side <= c1_side;
    end
  end

  // side normalize
  logic  v2;
  uvec_t n2;
  logic  z2;
  side_t side2;

  lav_norm u_norm_s (
    .clk(clk), .rst(rst), .en(en),
    .v_valid(c2_valid), .v(c2_s), .side_in(c2_side),
    .n_valid(v2), .n(n2), .zero(z2), .side_out(side2)
  );

  // degenerate items carry zero bases from here on
  logic  degen2;
  uvec_t sg, fg;

  always_comb begin
    degen2 = side2.degen | z2;
    sg     = degen2 ? '0 : n2;
    fg     = degen2 ? '0 : side2.fn;
  end

  logic                  d1_valid;
  logic signed [PW2-1:0] d1_q  [6];
  logic signed [PW1-1:0] d1_ds [3];
  logic signed [PW1-1:0] d1_df [3];
  uvec_t                 d1_s, d1_f;
  vec_t                  d1_eye;
  logic                  d1_degen;

  always_ff @(posedge clk) begin
    if (rst) d1_valid <= 1'b0;
    else if (en) d1_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_q[0] <= $signed(sg[1]) * $signed(fg[2]);
      d1_q[1] <= $signed(sg[2]) * $signed(fg[1]);
      d1_q[2] <= $signed(sg[2]) * $signed(fg[0]);
      d1_q[3] <= $signed(sg[0]) * $signed(fg[2]);
      d1_q[4] <= $signed(sg[0]) * $signed(fg[1]);
      d1_q[5] <= $signed(sg[1]) * $signed(fg[0]);
      for (int i = 0; i < 3; i++) begin
        d1_ds[i] <= $signed(sg[i]) * $signed(side2.eye[i]);
        d1_df[i] <= $signed(fg[i]) * $signed(side2.eye[i]);
      end
      d1_s     <= sg;
      d1_f     <= fg;
      d1_eye   <= side2.eye;
      d1_degen <= degen2;
    end
  end

  logic d2_valid;
  rec_t d2_rec;
  vec_t d2_eye;

  always_ff @(posedge clk) begin
    if (rst) d2_valid <= 1'b0;
    else if (en) d2_valid <= d1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_rec.s     <= d1_s;
      d2_rec.f     <= d1_f;
      d2_rec.degen <= d1_degen;
      d2_rec.u[0]  <= sat32(rescale(wide_t'(d1_q[0]) - wide_t'(d1_q[1])));
      d2_rec.u[1]  <= sat32(rescale(wide_t'(d1_q[2]) - wide_t'(d1_q[3])));
      d2_rec.u[2]  <= sat32(rescale(wide_t'(d1_q[4]) - wide_t'(d1_q[5])));
      d2_rec.c3[0] <= sat32(-rescale(wide_t'(d1_ds[0]) + wide_t'(d1_ds[1])
                                     + wide_t'(d1_ds[2])));
      d2_rec.c3[1] <= '0;
      d2_rec.c3[2] <= sat32(rescale(wide_t'(d1_df[0]) + wide_t'(d1_df[1])
                                    + wide_t'(d1_df[2])));
      d2_eye       <= d1_eye;
    end
  end

  // true up . eye
  logic                 d3_valid;
  rec_t                 d3_rec;
  logic signed [WW-1:0] d3_pu [3];

  always_ff @(posedge clk) begin
    if (rst) d3_valid <= 1'b0;
    else if (en) d3_valid <= d2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d3_pu[i] <= $signed(d2_rec.u[i]) * $signed(d2_eye[i]);
      d3_rec <= d2_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fin_valid <= 1'b0;
    else if (en) fin_valid <= d3_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin.s     <= d3_rec.s;
      fin.u     <= d3_rec.u;
      fin.f     <= d3_rec.f;
      fin.degen <= d3_rec.degen;
      fin.c3[0] <= d3_rec.c3[0];
      fin.c3[1] <= sat32(-rescale(d3_pu[0] + d3_pu[1] + d3_pu[2]));
      fin.c3[2] <= d3_rec.c3[2];
    end
  end

  // column serializer: four beats per item
  logic ov;
  col_t col;
  rec_t hold;
  logic ser_take;

  assign ser_take = !ov || (rsp_ready && col == LAST_COL);
  assign en       = !fin_valid || ser_take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      col <= '0;
    end else if (fin_valid && ser_take) begin
      ov  <= 1'b1;
      col <= '0;
    end else if (ov && rsp_ready) begin
      if (col == LAST_COL) ov <= 1'b0;
      col <= col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && ser_take) hold <= fin;
  end

  always_comb begin
    if (col == LAST_COL) begin
      elem_row0 = hold.c3[0];
      elem_row1 = hold.c3[1];
      elem_row2 = hold.c3[2];
      elem_row3 = Q_ONE;
    end else begin
      elem_row0 = FW'($signed(hold.s[col]));
      elem_row1 = hold.u[col];
      elem_row2 = FW'(-$signed(hold.f[col]));
      elem_row3 = '0;
    end
  end

  assign rsp_valid  = ov;
  assign column     = col;
  assign last       = (col == LAST_COL);
  assign degenerate = hold.degen;

endmodule

// ===== sv/look_at_view_matrix_top.sv =====
// Look-at view matrix builder, signed Q16.16.
// Request channel (req_valid/req_ready): one beat carries eye, target and up.
// Response channel (rsp_valid/rsp_ready): four beats per request, columns 0..3
// of the column-major view matrix; last marks column 3, degenerate is the same
// on all four beats and flags a zero-length forward or side vector.
// A request passes the front register, the queue and the back pipeline before its
// first column beat; the columns then follow one per cycle while rsp_ready is high.
// Request rate is bounded by the four column beats on the response port; the back
// pipeline (two 52-stage normalizers, each a 32-stage square root and a 17-stage
// divider) holds one request in every stage.
// A one-beat front register and a two-entry queue decouple request intake from
// the back pipeline.
// Reset clears all valid state; no request is in flight afterward.
// When the receiver stalls, the column on the port holds, the back pipeline runs on
// until a finished item waits for the serializer and then freezes, and requests keep
// landing in the queue and front register until both fill, then req_ready drops.
module look_at_view_matrix_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] elem_row0,
  output logic signed [31:0] elem_row1,
  output logic signed [31:0] elem_row2,
  output logic signed [31:0] elem_row3,
  output logic [1:0]         column,
  output logic               last,
  output logic               degenerate
);
  import lav_pkg::*;

  vec_t  eye_v, center_v, up_v;
  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  assign eye_v    = {eye_z, eye_y, eye_x};
  assign center_v = {center_z, center_y, center_x};
  assign up_v     = {up_z, up_y, up_x};

  lav_front u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .eye(eye_v), .center(center_v), .up(up_v),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
  );

  lav_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  lav_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(pop_valid), .in_ready(pop_ready), .in_item(pop_item),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .elem_row0(elem_row0), .elem_row1(elem_row1),
    .elem_row2(elem_row2), .elem_row3(elem_row3),
    .column(column), .last(last), .degenerate(degenerate)
  );

endmodule

// ===== sim/lav_checker.sv =====
`timescale 1ns / 1ps
module lav_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  logic signed [31:0] elem_row0,
  input  logic signed [31:0] elem_row1,
  input  logic signed [31:0] elem_row2,
  input  logic signed [31:0] elem_row3,
  input  logic [1:0]         column,
  input  logic               last,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending,
  output int                 columns_seen,
  output int                 degen_seen
);
  import lav_pkg::*;

  typedef struct {
    logic signed [31:0] row [4];
    col_t               col;
    logic               is_last;
    logic               degen;
  } column_t;

  column_t col_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // bitwise integer square root of a 64-bit value
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_len(ref longint v[3]);
    longint unsigned acc, m, len;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      acc += m * m;
    end
    len = int_root(acc);
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) v[i] = (v[i] * 65536) / longint'(len);
    return 1;
  endfunction

  function automatic void cross3(longint a[3], longint b[3], ref longint r[3]);
    r[0] = clamp32((a[1] * b[2] - a[2] * b[1]) / 65536);
    r[1] = clamp32((a[2] * b[0] - a[0] * b[2]) / 65536);
    r[2] = clamp32((a[0] * b[1] - a[1] * b[0]) / 65536);
  endfunction

  function automatic longint dot3(longint a[3], longint b[3]);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / 65536;
  endfunction

  task automatic predict_view(longint eye[3], longint ctr[3], longint upv[3]);
    longint fw[3], sd[3], tu[3], c3[4];
    bit degen;
    column_t c;
    degen = 0;
    for (int i = 0; i < 3; i++) fw[i] = clamp32(ctr[i] - eye[i]);
    if (!unit_len(fw)) degen = 1;
    else begin
      cross3(fw, upv, sd);
      if (!unit_len(sd)) degen = 1;
    end
    if (degen) begin
      for (int i = 0; i < 3; i++) begin
        fw[i] = 0; sd[i] = 0; tu[i] = 0;
      end
    end else begin
      cross3(sd, fw, tu);
    end
    c3[0] = clamp32(-dot3(sd, eye));
    c3[1] = clamp32(-dot3(tu, eye));
    c3[2] = clamp32(dot3(fw, eye));
    c3[3] = 65536;
    for (int k = 0; k < 4; k++) begin
      if (k < 3) begin
        c.row[0] = 32'(clamp32(sd[k]));
        c.row[1] = 32'(clamp32(tu[k]));
        c.row[2] = 32'(clamp32(-fw[k]));
        c.row[3] = '0;
      end else begin
        for (int i = 0; i < 4; i++) c.row[i] = 32'(c3[i]);
      end
      c.col = col_t'(k);
      c.is_last = (k == 3);
      c.degen = degen;
      col_q.push_back(c);
    end
  endtask

  assign pending = col_q.size();

  always @(posedge clk) begin
    column_t e;
    if (rst) begin
      errors <= 0;
      columns_seen <= 0;
      degen_seen <= 0;
    end else begin
      if (req_valid && req_ready)
        predict_view('{eye_x, eye_y, eye_z}, '{center_x, center_y, center_z},
                     '{up_x, up_y, up_z});
      if (rsp_valid && rsp_ready) begin
        columns_seen <= columns_seen + 1;
        if (degenerate) degen_seen <= degen_seen + 1;
        if (col_q.size() == 0) begin
          $display("%0t: unexpected column beat col=%0d", $time, column);
          errors <= errors + 1;
        end else begin
          e = col_q.pop_front();
          if (elem_row0 !== e.row[0] || elem_row1 !== e.row[1] ||
              elem_row2 !== e.row[2] || elem_row3 !== e.row[3] ||
              column !== e.col || last !== e.is_last || degenerate !== e.degen) begin
            $display("%0t: expected rows %0d %0d %0d %0d col %0d last %0b degen %0b",
                     $time, e.row[0], e.row[1], e.row[2], e.row[3], e.col,
                     e.is_last, e.degen);
            $display("%0t: actual   rows %0d %0d %0d %0d col %0d last %0b degen %0b",
                     $time, elem_row0, elem_row1, elem_row2, elem_row3, column,
                     last, degenerate);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
  logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
  logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
  logic rsp_valid;
  logic rsp_ready = 0;
  logic signed [31:0] elem_row0, elem_row1, elem_row2, elem_row3;
  logic [1:0] column;
  logic last, degenerate;
  int errors, pending, columns_seen, degen_seen;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int cycles = 0;
  int sent = 0;

  localparam int LIMIT = 400000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  look_at_view_matrix_top dut (.*);

  lav_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk)
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
    endcase
  endfunction

  // one request beat; valid stays high until accepted and drops only for idle cycles
  task automatic send_view(logic signed [31:0] v[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    {eye_x, eye_y, eye_z} <= {v[0], v[1], v[2]};
    {center_x, center_y, center_z} <= {v[3], v[4], v[5]};
    {up_x, up_y, up_z} <= {v[6], v[7], v[8]};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_view;
    logic signed [31:0] v[9];
    int m, k;
    m = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = rnd_coord(m < 4 ? 3 : m < 6 ? 1 : m < 9 ? 0 : 2);
    k = $urandom_range(0, 15);
    if (k == 0) for (int i = 0; i < 3; i++) v[3 + i] = v[i];          // eye on target
    else if (k == 1) for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] - v[i]; // up along forward
    else if (k == 2) for (int i = 6; i < 9; i++) v[i] = 0;
    send_view(v);
  endtask

  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] MX = 32'sh7fffffff;
  localparam logic signed [31:0] MN = 32'sh80000000;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: plain, degenerate and saturating views
    send_view('{0, 0, 0, 0, 0, -ONE, 0, ONE, 0});
    send_view('{ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0});
    send_view('{5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 0, ONE, 0});
    send_view('{0, 0, 0, 0, ONE, 0, 0, ONE, 0});
    send_view('{0, 0, 0, ONE, 0, 0, 0, 0, 0});
    send_view('{MN, MN, MN, MX, MX, MX, 0, ONE, 0});
    send_view('{MX, MX, MX, MN, MN, MN, MX, MN, MX});
    send_view('{MX, 0, MN, MN, MX, 0, ONE, ONE, ONE});
    send_view('{-1, -1, -1, 0, 0, 0, MN, MN, MN});
    send_view('{1, 0, 0, 0, 0, 0, 0, 1, 0});
    send_view('{0, 0, 0, 1, 1, 1, 0, 0, 1});
    send_view('{-ONE, 0, ONE, MX, MX, MN, MX, MX, MX});
    send_view('{MX, MX, MX, MX, MX, MX, 0, ONE, 0});
    send_view('{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
                32'sh33333333, 32'shcccccccc, 32'sh00ff00ff, 32'shff00ff00, 32'sh12345678});
    // pause until every column is back
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 51 : 24) : 0;
      recv_stall_pct = (ph == 2) ? 51 : (ph == 3 ? 24 : 0);
      for (int n = 0; n < 35; n++) random_view();
    end
    recv_stall_pct = 0;
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d view requests (%0d directed), checked %0d columns, %0d degenerate",
             sent, 14, columns_seen, degen_seen);
    $display("stall mixes: none, sender 51%%, receiver 51%%, both 24%%");
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
